/* hw/rtl/pip_pkg.sv */
package pip_pkg;

  // Request codes carried by the command field.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Orientation of an ordered point triple.
  typedef enum logic [1:0] {
    ORI_COLIN = 2'd0,
    ORI_CLOCK = 2'd1,
    ORI_CCW   = 2'd2
  } ori_t;

  // Which of the five orientations of one polygon side is being computed.
  // A and B are the side's end points, P the query point, F the far end of the ray.
  typedef enum logic [2:0] {
    ORI_ABP = 3'd0,
    ORI_ABF = 3'd1,
    ORI_PFA = 3'd2,
    ORI_PFB = 3'd3,
    ORI_APB = 3'd4
  } ori_sel_t;

  localparam int NUM_ORI = 5;

  // Fewest vertices that still make a polygon.
  localparam logic [3:0] MIN_VERTICES = 4'd3;

  // Issue side of the orientation unit.
  typedef struct packed {
    logic     vld;
    ori_sel_t sel;
  } ori_req_t;

  // Result side of the orientation unit.
  typedef struct packed {
    logic     vld;
    ori_sel_t sel;
    ori_t     code;
  } ori_rsp_t;

endpackage

/* hw/rtl/pip_orient.sv */
module pip_orient #(
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pip_pkg::ori_req_t     req_i,
  input  logic signed [CW-1:0]  p_x,
  input  logic signed [CW-1:0]  p_y,
  input  logic signed [CW-1:0]  q_x,
  input  logic signed [CW-1:0]  q_y,
  input  logic signed [CW-1:0]  r_x,
  input  logic signed [CW-1:0]  r_y,
  output pip_pkg::ori_rsp_t     rsp_o
);

  localparam int DW = CW + 1;
  localparam int MW = 2 * CW + 2;
  localparam int SW = 2 * CW + 3;

  pip_pkg::ori_req_t    sa_r;
  pip_pkg::ori_req_t    sb_r;
  pip_pkg::ori_rsp_t    rsp_r;

  logic signed [DW-1:0] d1_r, d2_r, d3_r, d4_r;
  logic signed [MW-1:0] m1_r, m2_r;
  logic signed [SW-1:0] diff;
  pip_pkg::ori_t        code;

  // Control pipeline: three stages from request to result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r  <= '0;
      sb_r  <= '0;
      rsp_r <= '0;
    end else begin
      sa_r      <= req_i;
      sb_r      <= sa_r;
      rsp_r.vld <= sb_r.vld;
      rsp_r.sel <= sb_r.sel;
      rsp_r.code <= code;
    end
  end

  // Stage one: the four coordinate differences.
  always_ff @(posedge clk) begin
    d1_r <= DW'(q_y) - DW'(p_y);
    d2_r <= DW'(r_x) - DW'(q_x);
    d3_r <= DW'(q_x) - DW'(p_x);
    d4_r <= DW'(r_y) - DW'(q_y);
  end

  // Stage two: the two exact cross products.
  always_ff @(posedge clk) begin
    m1_r <= d1_r * d2_r;
    m2_r <= d3_r * d4_r;
  end

  // Stage three: compare the products and classify the turn.
  always_comb begin
    diff = SW'(m1_r) - SW'(m2_r);
    if (diff == '0) begin
      code = pip_pkg::ORI_COLIN;
    end else if (diff[SW-1]) begin
      code = pip_pkg::ORI_CCW;
    end else begin
      code = pip_pkg::ORI_CLOCK;
    end
  end

  assign rsp_o = rsp_r;

endmodule

/* hw/rtl/point_in_polygon_test.sv */
// Ray-casting point-in-polygon test.
// Input channel (in_valid / in_stall): a request with in_command at write stores
// in_coord_x / in_coord_y as vertex in_vertex_index and gives no result; a request with
// in_command at query tests the point in_coord_x / in_coord_y against the polygon made of
// the first in_vertex_count stored vertices (saturated to MAX_VERTICES).
// Output channel (out_valid / out_stall): one result per query with out_inside_res (inside
// or on the boundary) and out_too_few_vertices (fewer than three vertices).
// One request is handled at a time; in_stall is high from acceptance of a query until its
// result is taken. A query with fewer than three vertices shows its result in the next
// cycle. Otherwise each polygon side passes through a vertex store read, five orientations
// issued to one shared three-stage orientation unit (two exact products), a drain until
// the last orientation returns and an evaluation. A query scans as many sides as the
// vertex count, or fewer when the point lies on the line of a crossed side.
// The result stays on the output registers while out_stall is high.
// Reset (rst_n low at a clock edge) returns the sequencer to idle and drops out_valid; the
// vertex store is not cleared and must be written before it is queried.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 8,
  parameter int COORD_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [2:0]  in_vertex_index,
  input  logic [15:0] in_coord_x,
  input  logic [15:0] in_coord_y,
  input  logic [3:0]  in_vertex_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_inside_res,
  output logic        out_too_few_vertices
);

  localparam int CW   = COORD_WIDTH;
  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int CNTW = (NW > 4) ? NW : 4;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_ISSUE = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_EVAL  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t              st_r, st_nxt;
  logic [IW-1:0]       i_r, i_nxt;
  logic [CNTW-1:0]     n_r, n_nxt;
  pip_pkg::ori_sel_t   sel_r, sel_nxt;
  logic                par_r, par_nxt;
  logic                res_in_r, res_in_nxt;
  logic                res_few_r, res_few_nxt;

  logic signed [CW-1:0] px_r, py_r;
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [CW-1:0] mem_x [MAX_VERTICES];
  logic signed [CW-1:0] mem_y [MAX_VERTICES];

  pip_pkg::ori_t        ori_r [pip_pkg::NUM_ORI];
  pip_pkg::ori_req_t    req;
  pip_pkg::ori_rsp_t    rsp;
  logic signed [CW-1:0] op_px, op_py, op_qx, op_qy, op_rx, op_ry;

  logic                 acc;
  logic [31:0]          fld_x, fld_y;
  logic signed [CW-1:0] in_x, in_y;
  logic signed [CW-1:0] far_x;
  logic [CNTW-1:0]      cnt_ext, cnt_sat;
  logic [CNTW-1:0]      nx_cnt;
  logic [IW-1:0]        nx;
  logic                 crossed, on_side;
  pip_pkg::ori_t        o1, o2, o3, o4, o5;

  // Bounding-box test: q lies within the box spanned by p and r.
  function automatic logic in_box(input logic signed [CW-1:0] bpx, input logic signed [CW-1:0] bpy,
                                  input logic signed [CW-1:0] bqx, input logic signed [CW-1:0] bqy,
                                  input logic signed [CW-1:0] brx, input logic signed [CW-1:0] bry);
    return ((bqx <= bpx) || (bqx <= brx)) && ((bqx >= bpx) || (bqx >= brx)) &&
           ((bqy <= bpy) || (bqy <= bry)) && ((bqy >= bpy) || (bqy >= bry));
  endfunction

  assign acc      = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);

  // Coordinates are the low COORD_WIDTH bits of the field, two's complement.
  assign fld_x = {16'b0, in_coord_x};
  assign fld_y = {16'b0, in_coord_y};
  assign in_x  = fld_x[CW-1:0];
  assign in_y  = fld_y[CW-1:0];
  assign far_x = {1'b0, {(CW-1){1'b1}}};

  // Saturate the vertex count to the store depth.
  assign cnt_ext = CNTW'(in_vertex_count);
  assign cnt_sat = (cnt_ext > CNTW'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES) : cnt_ext;

  // Index of the side's second vertex, wrapping to zero after the last one.
  assign nx_cnt = CNTW'(i_r) + CNTW'(1);
  assign nx     = (nx_cnt == n_r) ? '0 : nx_cnt[IW-1:0];

  // Vertex store write; slots beyond the store are dropped.
  always_ff @(posedge clk) begin
    if (acc && (in_command == pip_pkg::CMD_WRITE) && (int'(in_vertex_index) < MAX_VERTICES)) begin
      mem_x[IW'(in_vertex_index)] <= in_x;
      mem_y[IW'(in_vertex_index)] <= in_y;
    end
  end

  // Vertex store read of both end points of the current side.
  always_ff @(posedge clk) begin
    if (st_r == ST_FETCH) begin
      ax_r <= mem_x[i_r];
      ay_r <= mem_y[i_r];
      bx_r <= mem_x[nx];
      by_r <= mem_y[nx];
    end
  end

  // Query point capture.
  always_ff @(posedge clk) begin
    if (acc) begin
      px_r <= in_x;
      py_r <= in_y;
    end
  end

  // Operand selection for the shared orientation unit.
  always_comb begin
    req.vld = (st_r == ST_ISSUE);
    req.sel = sel_r;
    op_px = ax_r;  op_py = ay_r;
    op_qx = bx_r;  op_qy = by_r;
    op_rx = px_r;  op_ry = py_r;
    case (sel_r)
      pip_pkg::ORI_ABP: begin
        op_px = ax_r;  op_py = ay_r;
        op_qx = bx_r;  op_qy = by_r;
        op_rx = px_r;  op_ry = py_r;
      end
      pip_pkg::ORI_ABF: begin
        op_px = ax_r;  op_py = ay_r;
        op_qx = bx_r;  op_qy = by_r;
        op_rx = far_x; op_ry = py_r;
      end
      pip_pkg::ORI_PFA: begin
        op_px = px_r;  op_py = py_r;
        op_qx = far_x; op_qy = py_r;
        op_rx = ax_r;  op_ry = ay_r;
      end
      pip_pkg::ORI_PFB: begin
        op_px = px_r;  op_py = py_r;
        op_qx = far_x; op_qy = py_r;
        op_rx = bx_r;  op_ry = by_r;
      end
      pip_pkg::ORI_APB: begin
        op_px = ax_r;  op_py = ay_r;
        op_qx = px_r;  op_qy = py_r;
        op_rx = bx_r;  op_ry = by_r;
      end
      default: begin
        op_px = ax_r;  op_py = ay_r;
        op_qx = bx_r;  op_qy = by_r;
        op_rx = px_r;  op_ry = py_r;
      end
    endcase
  end

  pip_orient #(
    .CW (CW)
  ) u_orient (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (req),
    .p_x   (op_px),
    .p_y   (op_py),
    .q_x   (op_qx),
    .q_y   (op_qy),
    .r_x   (op_rx),
    .r_y   (op_ry),
    .rsp_o (rsp)
  );

  // Orientation results, one slot per orientation of the side.
  always_ff @(posedge clk) begin
    if (rsp.vld) begin
      ori_r[rsp.sel] <= rsp.code;
    end
  end

  // Side test: four-orientation intersection with the colinear cases.
  always_comb begin
    o1 = ori_r[pip_pkg::ORI_ABP];
    o2 = ori_r[pip_pkg::ORI_ABF];
    o3 = ori_r[pip_pkg::ORI_PFA];
    o4 = ori_r[pip_pkg::ORI_PFB];
    o5 = ori_r[pip_pkg::ORI_APB];
    on_side = in_box(ax_r, ay_r, px_r, py_r, bx_r, by_r);
    crossed = ((o1 != o2) && (o3 != o4)) ||
              ((o1 == pip_pkg::ORI_COLIN) && on_side) ||
              ((o2 == pip_pkg::ORI_COLIN) && in_box(ax_r, ay_r, far_x, py_r, bx_r, by_r)) ||
              ((o3 == pip_pkg::ORI_COLIN) && in_box(px_r, py_r, ax_r, ay_r, far_x, py_r)) ||
              ((o4 == pip_pkg::ORI_COLIN) && in_box(px_r, py_r, bx_r, by_r, far_x, py_r));
  end

  // Sequencer.
  always_comb begin
    st_nxt      = st_r;
    i_nxt       = i_r;
    n_nxt       = n_r;
    sel_nxt     = sel_r;
    par_nxt     = par_r;
    res_in_nxt  = res_in_r;
    res_few_nxt = res_few_r;
    case (st_r)
      ST_IDLE: begin
        if (acc && (in_command == pip_pkg::CMD_QUERY)) begin
          i_nxt   = '0;
          n_nxt   = cnt_sat;
          par_nxt = 1'b0;
          if (in_vertex_count < pip_pkg::MIN_VERTICES) begin
            res_in_nxt  = 1'b0;
            res_few_nxt = 1'b1;
            st_nxt      = ST_DONE;
          end else begin
            res_few_nxt = 1'b0;
            st_nxt      = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        sel_nxt = pip_pkg::ORI_ABP;
        st_nxt  = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (sel_r == pip_pkg::ORI_APB) begin
          st_nxt = ST_DRAIN;
        end else begin
          sel_nxt = pip_pkg::ori_sel_t'(sel_r + 3'd1);
        end
      end
      ST_DRAIN: begin
        if (rsp.vld && (rsp.sel == pip_pkg::ORI_APB)) begin
          st_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (crossed && (o5 == pip_pkg::ORI_COLIN)) begin
          // The point sits on the line of a crossed side: decided by that side alone.
          res_in_nxt = on_side;
          st_nxt     = ST_DONE;
        end else begin
          par_nxt = par_r ^ crossed;
          if (nx == '0) begin
            res_in_nxt = par_r ^ crossed;
            st_nxt     = ST_DONE;
          end else begin
            i_nxt  = nx;
            st_nxt = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        if (!out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    n_r       <= n_nxt;
    sel_r     <= sel_nxt;
    par_r     <= par_nxt;
    res_in_r  <= res_in_nxt;
    res_few_r <= res_few_nxt;
  end

  assign out_valid            = (st_r == ST_DONE);
  assign out_inside_res       = res_in_r;
  assign out_too_few_vertices = res_few_r;

endmodule
